### hdl/ow_pkg.sv
// Shared types, constants and register codes for the 1-wire bus master.
package ow_pkg;

    // Bits moved by one read or write operation
    localparam int BITS_PER_TRANSFER = 8;
    localparam int BIT_IDX_W = $clog2(BITS_PER_TRANSFER + 1);

    localparam int TICK_W     = 10;
    localparam int TIME_W     = 8;
    localparam int BYTE_W     = 8;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 3;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    // Reset values of the timing registers (standard speed)
    localparam logic [TICK_W-1:0] RESET_LOW_DEFAULT     = TICK_W'(602);
    localparam logic [TICK_W-1:0] PRESENCE_SAMPLE_DFLT  = TICK_W'(72);
    localparam logic [TICK_W-1:0] RESET_HIGH_DEFAULT    = TICK_W'(68 + 260 + 5 + 2);
    localparam logic [TIME_W-1:0] SLOT_DEFAULT          = TIME_W'(70);
    localparam logic [TIME_W-1:0] WRITE_ZERO_LOW_DFLT   = TIME_W'(63);
    localparam logic [TIME_W-1:0] WRITE_ONE_LOW_DFLT    = TIME_W'(7);
    localparam logic [TIME_W-1:0] READ_LOW_DEFAULT      = TIME_W'(7);
    localparam logic [TIME_W-1:0] READ_SAMPLE_DEFAULT   = TIME_W'(9);

    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_RST_LOW     = 3'd1,
        PH_RST_SAMPLE  = 3'd2,
        PH_RST_RECOVER = 3'd3,
        PH_SLOT_LOW    = 3'd4,
        PH_READ_SAMPLE = 3'd5,
        PH_SLOT_REST   = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_RESET = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_READ  = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RESET_LOW       = 3'd0,
        REG_PRESENCE_SAMPLE = 3'd1,
        REG_RESET_HIGH      = 3'd2,
        REG_SLOT            = 3'd3,
        REG_WRITE_ZERO_LOW  = 3'd4,
        REG_WRITE_ONE_LOW   = 3'd5,
        REG_READ_LOW        = 3'd6,
        REG_READ_SAMPLE     = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [TICK_W-1:0] reset_low_time;
        logic [TICK_W-1:0] presence_sample_time;
        logic [TICK_W-1:0] reset_high_time;
        logic [TIME_W-1:0] slot_time;
        logic [TIME_W-1:0] write_zero_low_time;
        logic [TIME_W-1:0] write_one_low_time;
        logic [TIME_W-1:0] read_low_time;
        logic [TIME_W-1:0] read_sample_time;
    } cfg_t;

endpackage

### hdl/onewire_bus_master_top.sv
// Top level of the 1-wire bus master: sequencer state and registered result stage.
//
// One request is taken per clock and every request gives exactly one result, which
// appears in the result register on the cycle after acceptance. A request is a tick
// of one microsecond (carrying the sampled bus level) or a command (reset, write
// byte, read byte); commands arriving while an operation runs are ignored. The
// sequencer state is updated in the same cycle the request is taken, so ticks may
// arrive back to back at the full clock rate. in_stall is raised only while the
// result register holds an untaken result and out_stall is high; a new request is
// accepted in the same cycle the waiting result leaves. Timing registers are
// written through cfg_write / cfg_index / cfg_data and should only change while idle.
module onewire_bus_master_top (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration writes
    input  logic                           cfg_write,
    input  logic [ow_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ow_pkg::CFG_DATA_W-1:0]  cfg_data,
    // request channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     action,
    input  logic [ow_pkg::BYTE_W-1:0]      write_data,
    input  logic                           bus_level,
    // result channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           drive_low,
    output logic                           busy_res,
    output logic                           done_res,
    output logic                           status,
    output logic [ow_pkg::BYTE_W-1:0]      read_data
);

    ow_pkg::cfg_t cfg;

    ow_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequencer state
    ow_pkg::phase_t                   phase_reg, phase_next;
    ow_pkg::action_t                  op_kind_reg, op_kind_next;
    logic [ow_pkg::TICK_W-1:0]        tick_count_reg, tick_count_next;
    logic [ow_pkg::BIT_IDX_W-1:0]     bit_index_reg, bit_index_next;
    logic [ow_pkg::BYTE_W-1:0]        shift_byte_reg, shift_byte_next;
    logic                             line_driven_reg, line_driven_next;
    logic [ow_pkg::BYTE_W-1:0]        last_read_reg, last_read_next;

    // Result stage
    logic                             out_valid_reg, out_valid_next;
    logic                             drive_low_reg;
    logic                             busy_reg;
    logic                             done_reg;
    logic                             status_reg;
    logic [ow_pkg::BYTE_W-1:0]        read_data_reg;

    logic                             accept;
    logic                             step_done;
    logic                             step_status;
    logic [ow_pkg::TICK_W-1:0]        tick_inc;
    logic [ow_pkg::TICK_W-1:0]        low_limit;
    logic [ow_pkg::BYTE_W-1:0]        shifted_byte;
    logic [ow_pkg::BYTE_W-1:0]        read_mask;
    logic [ow_pkg::BIT_IDX_W-1:0]     bit_index_inc;
    ow_pkg::action_t                  act;

    // Stall only while a result waits and the far side holds it
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign act      = ow_pkg::action_t'(action);

    // Helpers: saturating tick, current write bit, read bit mask
    assign tick_inc      = (tick_count_reg == ow_pkg::TICK_MAX)
                           ? tick_count_reg
                           : tick_count_reg + ow_pkg::TICK_W'(1);
    assign shifted_byte  = shift_byte_reg >> bit_index_reg;
    assign read_mask     = ow_pkg::BYTE_W'(1) << bit_index_reg;
    assign bit_index_inc = bit_index_reg + ow_pkg::BIT_IDX_W'(1);

    // Low time of the current slot
    always_comb
    begin
        if (op_kind_reg == ow_pkg::ACT_READ)
            low_limit = ow_pkg::TICK_W'(cfg.read_low_time);
        else if (shifted_byte[0])
            low_limit = ow_pkg::TICK_W'(cfg.write_one_low_time);
        else
            low_limit = ow_pkg::TICK_W'(cfg.write_zero_low_time);
    end

    // Next state of the sequencer for the accepted request
    always_comb
    begin
        phase_next       = phase_reg;
        op_kind_next     = op_kind_reg;
        tick_count_next  = tick_count_reg;
        bit_index_next   = bit_index_reg;
        shift_byte_next  = shift_byte_reg;
        line_driven_next = line_driven_reg;
        last_read_next   = last_read_reg;
        step_done        = 1'b0;
        step_status      = 1'b0;

        if (act != ow_pkg::ACT_TICK)
        begin
            // Command: start only when idle
            if (phase_reg == ow_pkg::PH_IDLE)
            begin
                op_kind_next     = act;
                tick_count_next  = '0;
                bit_index_next   = '0;
                line_driven_next = 1'b1;
                if (act == ow_pkg::ACT_RESET)
                begin
                    phase_next = ow_pkg::PH_RST_LOW;
                end
                else
                begin
                    shift_byte_next = (act == ow_pkg::ACT_WRITE) ? write_data : '0;
                    phase_next      = ow_pkg::PH_SLOT_LOW;
                end
            end
        end
        else if (phase_reg != ow_pkg::PH_IDLE)
        begin
            tick_count_next = tick_inc;
            case (phase_reg)
                ow_pkg::PH_RST_LOW:
                begin
                    if (tick_inc >= cfg.reset_low_time)
                    begin
                        line_driven_next = 1'b0;
                        tick_count_next  = '0;
                        phase_next       = ow_pkg::PH_RST_SAMPLE;
                    end
                end
                ow_pkg::PH_RST_SAMPLE:
                begin
                    if (tick_inc >= cfg.presence_sample_time)
                    begin
                        if (bus_level)
                        begin
                            // No presence pulse: finish at once
                            step_status      = 1'b1;
                            step_done        = 1'b1;
                            phase_next       = ow_pkg::PH_IDLE;
                            line_driven_next = 1'b0;
                            tick_count_next  = '0;
                        end
                        else
                        begin
                            phase_next = ow_pkg::PH_RST_RECOVER;
                        end
                    end
                end
                ow_pkg::PH_RST_RECOVER:
                begin
                    if (tick_inc >= cfg.reset_high_time)
                    begin
                        step_done        = 1'b1;
                        phase_next       = ow_pkg::PH_IDLE;
                        line_driven_next = 1'b0;
                        tick_count_next  = '0;
                    end
                end
                ow_pkg::PH_SLOT_LOW:
                begin
                    if (tick_inc >= low_limit)
                    begin
                        line_driven_next = 1'b0;
                        phase_next = (op_kind_reg == ow_pkg::ACT_READ) ? ow_pkg::PH_READ_SAMPLE
                                                                       : ow_pkg::PH_SLOT_REST;
                    end
                end
                ow_pkg::PH_READ_SAMPLE:
                begin
                    if (tick_inc >= ow_pkg::TICK_W'(cfg.read_sample_time))
                    begin
                        // Bits past the byte fall off the mask
                        if (bus_level)
                            shift_byte_next = shift_byte_reg | read_mask;
                        phase_next = ow_pkg::PH_SLOT_REST;
                    end
                end
                ow_pkg::PH_SLOT_REST:
                begin
                    if (tick_inc >= ow_pkg::TICK_W'(cfg.slot_time))
                    begin
                        bit_index_next = bit_index_inc;
                        if (bit_index_inc >= ow_pkg::BIT_IDX_W'(ow_pkg::BITS_PER_TRANSFER))
                        begin
                            if (op_kind_reg == ow_pkg::ACT_READ)
                                last_read_next = shift_byte_reg;
                            step_done        = 1'b1;
                            phase_next       = ow_pkg::PH_IDLE;
                            line_driven_next = 1'b0;
                            tick_count_next  = '0;
                        end
                        else
                        begin
                            phase_next       = ow_pkg::PH_SLOT_LOW;
                            tick_count_next  = '0;
                            line_driven_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    phase_next       = ow_pkg::PH_IDLE;
                    line_driven_next = 1'b0;
                end
            endcase
        end
    end

    // Sequencer registers advance only on an accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= ow_pkg::PH_IDLE;
            op_kind_reg     <= ow_pkg::ACT_TICK;
            tick_count_reg  <= '0;
            bit_index_reg   <= '0;
            shift_byte_reg  <= '0;
            line_driven_reg <= 1'b0;
            last_read_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            op_kind_reg     <= op_kind_next;
            tick_count_reg  <= tick_count_next;
            bit_index_reg   <= bit_index_next;
            shift_byte_reg  <= shift_byte_next;
            line_driven_reg <= line_driven_next;
            last_read_reg   <= last_read_next;
        end
    end

    // Result valid: set by a new request, held while stalled
    assign out_valid_next = accept || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            drive_low_reg <= line_driven_next;
            busy_reg      <= (phase_next != ow_pkg::PH_IDLE);
            done_reg      <= step_done;
            status_reg    <= step_status;
            read_data_reg <= last_read_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign drive_low = drive_low_reg;
    assign busy_res  = busy_reg;
    assign done_res  = done_reg;
    assign status    = status_reg;
    assign read_data = read_data_reg;

    // Checks
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && done_reg) |-> !busy_reg)
        else $error("completion reported while still busy");

    a_status_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg) |-> done_reg)
        else $error("status raised without completion");

    a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == ow_pkg::PH_IDLE) |-> !line_driven_reg)
        else $error("line driven while idle");

    a_bit_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_index_reg <= ow_pkg::BIT_IDX_W'(ow_pkg::BITS_PER_TRANSFER))
        else $error("bit index beyond transfer length");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted request produced no result");

endmodule

### hdl/ow_cfg.sv
// Timing register file of the 1-wire bus master.
module ow_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [ow_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ow_pkg::CFG_DATA_W-1:0]  cfg_data,
    output ow_pkg::cfg_t                   cfg
);

    ow_pkg::cfg_t cfg_reg;
    ow_pkg::cfg_t cfg_next;

    // Decode the write into the addressed register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                ow_pkg::REG_RESET_LOW:
                    cfg_next.reset_low_time = cfg_data[ow_pkg::TICK_W-1:0];
                ow_pkg::REG_PRESENCE_SAMPLE:
                    cfg_next.presence_sample_time = cfg_data[ow_pkg::TICK_W-1:0];
                ow_pkg::REG_RESET_HIGH:
                    cfg_next.reset_high_time = cfg_data[ow_pkg::TICK_W-1:0];
                ow_pkg::REG_SLOT:
                    cfg_next.slot_time = cfg_data[ow_pkg::TIME_W-1:0];
                ow_pkg::REG_WRITE_ZERO_LOW:
                    cfg_next.write_zero_low_time = cfg_data[ow_pkg::TIME_W-1:0];
                ow_pkg::REG_WRITE_ONE_LOW:
                    cfg_next.write_one_low_time = cfg_data[ow_pkg::TIME_W-1:0];
                ow_pkg::REG_READ_LOW:
                    cfg_next.read_low_time = cfg_data[ow_pkg::TIME_W-1:0];
                ow_pkg::REG_READ_SAMPLE:
                    cfg_next.read_sample_time = cfg_data[ow_pkg::TIME_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // Register bank, loaded with standard-speed timings at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_time       <= ow_pkg::RESET_LOW_DEFAULT;
            cfg_reg.presence_sample_time <= ow_pkg::PRESENCE_SAMPLE_DFLT;
            cfg_reg.reset_high_time      <= ow_pkg::RESET_HIGH_DEFAULT;
            cfg_reg.slot_time            <= ow_pkg::SLOT_DEFAULT;
            cfg_reg.write_zero_low_time  <= ow_pkg::WRITE_ZERO_LOW_DFLT;
            cfg_reg.write_one_low_time   <= ow_pkg::WRITE_ONE_LOW_DFLT;
            cfg_reg.read_low_time        <= ow_pkg::READ_LOW_DEFAULT;
            cfg_reg.read_sample_time     <= ow_pkg::READ_SAMPLE_DEFAULT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
